/* hw/rtl/lzss_window_decoder_macros.svh */
// ----------------------------------------------------------------------------
// lzss_window_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef LZSS_WINDOW_DECODER_MACROS_SVH
`define LZSS_WINDOW_DECODER_MACROS_SVH

// antecedent implies consequent on the same edge, quiet while in reset
`define LZWD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds on every edge out of reset
`define LZWD_ASSERT_ALWAYS(lbl, cond, msg) \
    `LZWD_ASSERT_IMPLIES(lbl, 1'b1, cond, msg)

`endif

/* hw/rtl/lzwd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_pkg
// Word types and fixed codes of the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       stream_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
    } t_out_word;

    localparam int POS_W = 12;

    localparam logic [1:0] PH_FLAG   = 2'd0;
    localparam logic [1:0] PH_TOKEN  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    localparam logic [7:0] SPACE_CHAR    = 8'h20;
    localparam logic [7:0] FLAG_SENTINEL = 8'hff;

endpackage
`default_nettype wire

/* hw/rtl/lzwd_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_out_fifo
// Two-word output queue; decouples the window pipeline from output stalls.
// ----------------------------------------------------------------------------
module lzwd_out_fifo
    import lzwd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_word i_push_word,
    output logic [1:0]     o_count,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    t_out_word  r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       c_pop;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_word  = r_mem[r_rd];
    assign o_count     = r_cnt;
    assign c_pop       = o_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (c_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, c_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_word;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lzss_window_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS decoder with a wrapping history window held in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | signals                                | word
//  --------+----------------------------------------+-------------------------
//  input   | i_in_valid  o_in_ready   i_in_word     | code_byte, stream_last
//  output  | o_out_valid i_out_ready  o_out_word    | plain_byte, byte_valid,
//          |                                        | run_last, stream_end
//
//  Flag, literal and first reference bytes are each taken in ST_IDLE when credit allows.
//  A reference copies len bytes (3 to 18), one window byte per cycle from the
//  single RAM read port while queue credit allows; a position beyond a smaller
//  window first folds back into range in ST_FOLD by repeated subtraction of WINDOW_SIZE.
//  Literals and copied bytes are registered in stage one, then in the output queue.
//  Reset needs no clearing pass: a fill count marks written window entries.
//  Output stalls hold the copy via a two-word queue and in-flight credit.
// ----------------------------------------------------------------------------
`include "lzss_window_decoder_macros.svh"

module lzss_window_decoder
    import lzwd_pkg::*;
#(
    parameter int WINDOW_SIZE     = 4096,
    parameter int LOOKAHEAD_SIZE  = 18,
    parameter int MATCH_THRESHOLD = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_word
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int FW = $clog2(WINDOW_SIZE + 1);
    localparam int LW = $clog2(MATCH_THRESHOLD + 17);

    localparam logic [AW-1:0]    LP_WPOS_INIT = AW'(WINDOW_SIZE - LOOKAHEAD_SIZE);
    localparam logic [AW-1:0]    LP_WLAST     = AW'(WINDOW_SIZE - 1);
    localparam logic [AW-1:0]    LP_LOOKAHEAD = AW'(LOOKAHEAD_SIZE);
    localparam logic [FW-1:0]    LP_FILL_MAX  = FW'(WINDOW_SIZE);
    localparam logic [POS_W:0]   LP_WIN_EXT   = (POS_W + 1)'(WINDOW_SIZE);
    localparam logic [POS_W-1:0] LP_WIN_POS   = POS_W'(WINDOW_SIZE);
    localparam logic [POS_W-1:0] LP_POS_WLAST = POS_W'(WINDOW_SIZE - 1);
    localparam logic [LW-1:0]    LP_LEN_BASE  = LW'(MATCH_THRESHOLD + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FOLD = 2'd1;
    localparam logic [1:0] ST_COPY = 2'd2;

    // control state
    logic [1:0]       r_state,  n_state;
    logic [1:0]       r_phase,  n_phase;
    logic [15:0]      r_flags,  n_flags;
    logic [7:0]       r_low,    n_low;
    logic [AW-1:0]    r_wpos,   n_wpos;
    logic [FW-1:0]    r_fill,   n_fill;
    logic [POS_W-1:0] r_addr,   n_addr;
    logic [LW-1:0]    r_left,   n_left;
    logic             r_last,   n_last;
    logic             r_s1_valid;

    // stage-one payload
    logic             r_s1_mem;
    logic [7:0]       r_s1_lit;
    logic             r_s1_bvalid;
    logic             r_s1_rl;
    logic             r_s1_end;
    logic [AW-1:0]    r_s1_waddr;
    logic             r_s1_fwd;
    logic [7:0]       r_s1_fwd_byte;
    logic             r_s1_inwin;
    logic [7:0]       r_s1_init;

    logic [7:0]       r_win [WINDOW_SIZE];
    logic [7:0]       r_rdata;

    logic             c_accept;
    logic             c_pop;
    logic             c_credit;
    logic [2:0]       c_occ;
    logic [1:0]       c_fifo_cnt;
    logic [15:0]      c_flags_sh;
    logic [AW-1:0]    c_rd_idx;
    logic [AW-1:0]    c_dist;
    logic             c_inwin;
    logic [7:0]       c_init;
    logic             c_fwd;
    logic [7:0]       c_s1_byte;
    logic             c_issue;
    logic             c_mem;
    logic [7:0]       c_lit;
    logic             c_bvalid;
    logic             c_rl;
    logic             c_end;
    logic             c_do_reset;
    logic [POS_W-1:0] c_pos;
    t_out_word        c_push_word;

    assign c_pop      = o_out_valid & i_out_ready;
    assign c_occ      = {1'b0, c_fifo_cnt} + {2'b00, r_s1_valid};
    assign c_credit   = c_occ < ({2'b00, c_pop} + 3'd2);
    assign o_in_ready = (r_state == ST_IDLE) & c_credit;
    assign c_accept   = i_in_valid & o_in_ready;
    assign c_flags_sh = {1'b0, r_flags[15:1]};
    assign c_pos      = {i_in_word.code_byte[7:4], r_low};

    // window lookup for the copy read
    assign c_rd_idx = r_addr[AW-1:0];
    assign c_dist   = (c_rd_idx >= LP_WPOS_INIT) ? (c_rd_idx - LP_WPOS_INIT)
                                                 : (c_rd_idx + LP_LOOKAHEAD);
    assign c_inwin  = FW'(c_dist) < r_fill;
    assign c_init   = (c_rd_idx < LP_WPOS_INIT) ? SPACE_CHAR : 8'h00;
    assign c_fwd    = r_s1_valid & r_s1_bvalid & ~r_s1_end & (r_s1_waddr == c_rd_idx);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_low      = r_low;
        n_wpos     = r_wpos;
        n_fill     = r_fill;
        n_addr     = r_addr;
        n_left     = r_left;
        n_last     = r_last;
        c_issue    = 1'b0;
        c_mem      = 1'b0;
        c_lit      = 8'h00;
        c_bvalid   = 1'b0;
        c_rl       = 1'b0;
        c_end      = 1'b0;
        c_do_reset = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (c_accept) begin
                    priority case (r_phase)
                        PH_TOKEN: begin
                            if (r_flags[0]) begin
                                c_issue  = 1'b1;
                                c_lit    = i_in_word.code_byte;
                                c_bvalid = 1'b1;
                                c_rl     = 1'b1;
                                c_end    = i_in_word.stream_last;
                                n_flags  = c_flags_sh;
                                n_phase  = c_flags_sh[8] ? PH_TOKEN : PH_FLAG;
                            end else begin
                                n_low   = i_in_word.code_byte;
                                n_phase = PH_SECOND;
                                c_issue = i_in_word.stream_last;
                                c_rl    = 1'b1;
                                c_end   = 1'b1;
                            end
                            c_do_reset = i_in_word.stream_last;
                        end
                        PH_SECOND: begin
                            n_addr  = c_pos;
                            n_left  = LW'(i_in_word.code_byte[3:0]) + LP_LEN_BASE;
                            n_last  = i_in_word.stream_last;
                            n_flags = c_flags_sh;
                            n_phase = c_flags_sh[8] ? PH_TOKEN : PH_FLAG;
                            n_state = ({1'b0, c_pos} >= LP_WIN_EXT) ? ST_FOLD : ST_COPY;
                        end
                        default: begin
                            n_flags    = {FLAG_SENTINEL, i_in_word.code_byte};
                            n_phase    = PH_TOKEN;
                            c_issue    = i_in_word.stream_last;
                            c_rl       = 1'b1;
                            c_end      = 1'b1;
                            c_do_reset = i_in_word.stream_last;
                        end
                    endcase
                end
            end
            ST_FOLD: begin
                if ({1'b0, r_addr} >= LP_WIN_EXT) begin
                    n_addr = r_addr - LP_WIN_POS;
                end else begin
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                if (c_credit) begin
                    c_issue  = 1'b1;
                    c_mem    = 1'b1;
                    c_bvalid = 1'b1;
                    c_rl     = (r_left == LW'(1));
                    c_end    = (r_left == LW'(1)) & r_last;
                    n_addr   = (r_addr == LP_POS_WLAST) ? '0 : r_addr + 1'b1;
                    n_left   = r_left - 1'b1;
                    if (r_left == LW'(1)) begin
                        n_state    = ST_IDLE;
                        c_do_reset = r_last;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (c_issue && c_bvalid) begin
            n_wpos = (r_wpos == LP_WLAST) ? '0 : r_wpos + 1'b1;
            n_fill = (r_fill == LP_FILL_MAX) ? r_fill : r_fill + 1'b1;
        end
        if (c_do_reset) begin
            n_wpos  = LP_WPOS_INIT;
            n_fill  = '0;
            n_flags = '0;
            n_phase = PH_FLAG;
            n_low   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_FLAG;
            r_flags    <= '0;
            r_low      <= '0;
            r_wpos     <= LP_WPOS_INIT;
            r_fill     <= '0;
            r_addr     <= '0;
            r_left     <= '0;
            r_last     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_flags    <= n_flags;
            r_low      <= n_low;
            r_wpos     <= n_wpos;
            r_fill     <= n_fill;
            r_addr     <= n_addr;
            r_left     <= n_left;
            r_last     <= n_last;
            r_s1_valid <= c_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_issue) begin
            r_s1_mem      <= c_mem;
            r_s1_lit      <= c_lit;
            r_s1_bvalid   <= c_bvalid;
            r_s1_rl       <= c_rl;
            r_s1_end      <= c_end;
            r_s1_waddr    <= r_wpos;
            r_s1_fwd      <= c_fwd;
            r_s1_fwd_byte <= c_s1_byte;
            r_s1_inwin    <= c_inwin;
            r_s1_init     <= c_init;
        end
    end

    // byte leaving stage one: literal, forwarded write, stored or reset value
    always_comb begin
        priority if (!r_s1_mem) begin
            c_s1_byte = r_s1_lit;
        end else if (r_s1_fwd) begin
            c_s1_byte = r_s1_fwd_byte;
        end else if (r_s1_inwin) begin
            c_s1_byte = r_rdata;
        end else begin
            c_s1_byte = r_s1_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_bvalid) begin
            r_win[r_s1_waddr] <= c_s1_byte;
        end
        r_rdata <= r_win[c_rd_idx];
    end

    assign c_push_word.plain_byte = c_s1_byte;
    assign c_push_word.byte_valid = r_s1_bvalid;
    assign c_push_word.run_last   = r_s1_rl;
    assign c_push_word.stream_end = r_s1_end;

    lzwd_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_word (c_push_word),
        .o_count     (c_fifo_cnt),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    `LZWD_ASSERT_ALWAYS(a_queue_credit, c_occ <= 3'd2, "output queue overcommitted")
    `LZWD_ASSERT_IMPLIES(a_end_resets, r_s1_valid && r_s1_end,
        (r_wpos == LP_WPOS_INIT) && (r_fill == '0), "stream end did not rewind window")
    `LZWD_ASSERT_IMPLIES(a_run_phase, r_state != ST_IDLE, r_phase != PH_SECOND,
        "reference still pending during copy")
    `LZWD_ASSERT_IMPLIES(a_copy_count, r_state == ST_COPY, r_left != '0,
        "copy running with no bytes left")

endmodule
`default_nettype wire
